### rtl/mm_pkg.sv
// Shared types and constants of the matrix multiply block.
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 4;
   localparam int ELEM_W   = 16;
   localparam int PROD_W   = 2 * ELEM_W;
   localparam int SUM_W    = 36;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Action codes on the request channel.
   localparam logic [ACTION_W-1:0] ACT_WRITE_A = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE_B = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

   // Work classes handed from the front to the back.
   typedef enum logic [1:0] {
      OP_WRITE_A,
      OP_WRITE_B,
      OP_COMPUTE,
      OP_COMPUTE_ZERO
   } mm_op_type;

   typedef struct packed {
      mm_op_type                op;
      logic [INDEX_W-1:0]       row;
      logic [INDEX_W-1:0]       col;
      logic signed [ELEM_W-1:0] value;
   } mm_entry_type;

   typedef struct packed {
      logic         valid;
      mm_entry_type entry;
   } mm_cmd_type;

   typedef struct packed {
      logic [INDEX_W-1:0]      row;
      logic [INDEX_W-1:0]      col;
      logic signed [SUM_W-1:0] sum;
   } mm_result_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_DRAIN,
      BK_DONE
   } mm_back_state_type;

endpackage : mm_pkg

`default_nettype wire

### rtl/mm_front.sv
// Request front end: classify request beats and drop the ones with no effect.
`timescale 1ns / 1ps
`default_nettype none

module mm_front #(
   parameter int DIM = 16
) (
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [mm_pkg::ACTION_W-1:0]   req_action,
   input  wire logic [mm_pkg::INDEX_W-1:0]    req_row,
   input  wire logic [mm_pkg::INDEX_W-1:0]    req_col,
   input  wire logic [mm_pkg::ELEM_W-1:0]     req_value,
   input  wire logic                          queue_full,
   output      mm_pkg::mm_cmd_type            push
);
   import mm_pkg::*;

   localparam int IDX_W = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int CMP_W = ((IDX_W > INDEX_W) ? IDX_W : INDEX_W) + 1;

   logic in_range;
   logic keep;
   logic take;

   assign in_range   = (CMP_W'(req_row) < CMP_W'(DIM)) && (CMP_W'(req_col) < CMP_W'(DIM));
   assign req_tready = !queue_full;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      push.entry.row   = req_row;
      push.entry.col   = req_col;
      push.entry.value = req_value;
      push.entry.op    = OP_COMPUTE_ZERO;
      keep             = 1'b0;
      unique case (req_action)
         ACT_WRITE_A: begin
            push.entry.op = OP_WRITE_A;
            keep          = in_range;
         end
         ACT_WRITE_B: begin
            push.entry.op = OP_WRITE_B;
            keep          = in_range;
         end
         ACT_COMPUTE: begin
            push.entry.op = in_range ? OP_COMPUTE : OP_COMPUTE_ZERO;
            keep          = 1'b1;
         end
         default: begin
            // unused action: drop
            keep = 1'b0;
         end
      endcase
      push.valid = take && keep && !reset;
   end

endmodule : mm_front

`default_nettype wire

### rtl/mm_queue.sv
// Short command queue between the front end and the compute back end.
`timescale 1ns / 1ps
`default_nettype none

module mm_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mm_pkg::mm_cmd_type  push,
   output      logic                full,
   output      mm_pkg::mm_cmd_type  head,
   input  wire logic                pop
);
   import mm_pkg::*;

   mm_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule : mm_queue

`default_nettype wire

### rtl/mm_back.sv
// Compute back end: matrix stores, multiply-accumulate sweep and result register.
`timescale 1ns / 1ps
`default_nettype none

module mm_back #(
   parameter int DIM = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mm_pkg::mm_cmd_type     head,
   output      logic                   pop,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      mm_pkg::mm_result_type  rsp_result
);
   import mm_pkg::*;

   localparam int IDX_W = (DIM > 1) ? $clog2(DIM) : 1;

   logic signed [ELEM_W-1:0] mem_a [DIM][DIM];
   logic signed [ELEM_W-1:0] mem_b [DIM][DIM];

   mm_back_state_type state_ff, state_in;

   logic [IDX_W-1:0]         row_ff, row_in;
   logic [IDX_W-1:0]         col_ff, col_in;
   logic [INDEX_W-1:0]       tag_row_ff, tag_row_in;
   logic [INDEX_W-1:0]       tag_col_ff, tag_col_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic                     rd_vld_ff;
   logic                     mul_vld_ff;
   logic signed [ELEM_W-1:0] a_q_ff;
   logic signed [ELEM_W-1:0] b_q_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mm_result_type            rsp_ff;

   logic [IDX_W-1:0] head_row;
   logic [IDX_W-1:0] head_col;
   logic             wr_a;
   logic             wr_b;
   logic             start;
   logic             issue;
   logic             load_rsp;
   logic             last_k;
   logic             drained;
   logic             out_free;

   assign head_row = IDX_W'(head.entry.row);
   assign head_col = IDX_W'(head.entry.col);
   assign last_k   = (k_ff == IDX_W'(DIM - 1));
   assign drained  = !rd_vld_ff && !mul_vld_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid && head.entry.op == OP_COMPUTE) begin
               state_in = BK_RUN;
            end else if (head.valid && head.entry.op == OP_COMPUTE_ZERO) begin
               state_in = BK_DONE;
            end
         end
         BK_RUN: begin
            if (last_k) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (drained) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop      = 1'b0;
      wr_a     = 1'b0;
      wr_b     = 1'b0;
      start    = 1'b0;
      issue    = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop   = head.valid;
            wr_a  = head.valid && head.entry.op == OP_WRITE_A;
            wr_b  = head.valid && head.entry.op == OP_WRITE_B;
            start = head.valid && (head.entry.op == OP_COMPUTE ||
                                   head.entry.op == OP_COMPUTE_ZERO);
         end
         BK_RUN:   issue    = 1'b1;
         BK_DRAIN: issue    = 1'b0;
         BK_DONE:  load_rsp = out_free;
         default:  issue    = 1'b0;
      endcase
   end

   always_comb begin
      row_in     = start ? head_row : row_ff;
      col_in     = start ? head_col : col_ff;
      tag_row_in = start ? head.entry.row : tag_row_ff;
      tag_col_in = start ? head.entry.col : tag_col_ff;
      k_in       = start ? '0 : (issue ? k_ff + 1'b1 : k_ff);
      priority if (start) begin
         acc_in = '0;
      end else if (mul_vld_ff) begin
         acc_in = acc_ff + SUM_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
      priority if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= issue;
         mul_vld_ff   <= rd_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      col_ff     <= col_in;
      tag_row_ff <= tag_row_in;
      tag_col_ff <= tag_col_in;
      k_ff       <= k_in;
      acc_ff     <= acc_in;
      prod_ff    <= a_q_ff * b_q_ff;
      if (load_rsp) begin
         rsp_ff.row <= tag_row_ff;
         rsp_ff.col <= tag_col_ff;
         rsp_ff.sum <= acc_ff;
      end
   end

   // A store: one write port, one registered read port walking along a row
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[head_row][head_col] <= head.entry.value;
      end
      a_q_ff <= mem_a[row_ff][k_ff];
   end

   // B store: one write port, one registered read port walking down a column
   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[head_row][head_col] <= head.entry.value;
      end
      b_q_ff <= mem_b[k_ff][col_ff];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule : mm_back

`default_nettype wire

### rtl/matrix_multiply.sv
// Top level of the matrix multiply block: request front end, queue, compute back end.
// Path: a write beat is registered in a queue slot and then written to its store; a compute
//   beat passes the store reads, product register and accumulator to the result register.
// Throughput: one compute at a time, set by the single multiply-accumulate unit that sweeps
//   one A row and one B column through one read port per store; writes 1/cycle when idle.
// Reset: clears the queue, the sequencer and the result valid; the matrix stores are
//   not cleared and hold undefined data until written.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply #(
   parameter int DIM = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request beats
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   // [1:0] action, [5:2] row_index, [9:6] col_index, [25:10] element_value, rest zero
   input  wire logic [mm_pkg::REQ_DATA_W-1:0] req_tdata,
   // result beats
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [3:0] result_row, [7:4] result_col, [43:8] product_value, rest zero
   output      logic [mm_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mm_pkg::*;

   localparam int ROW_LO = ACTION_W;
   localparam int COL_LO = ROW_LO + INDEX_W;
   localparam int VAL_LO = COL_LO + INDEX_W;
   localparam int RSP_USED_W = 2 * INDEX_W + SUM_W;

   mm_cmd_type    push;
   mm_cmd_type    head;
   logic          queue_full;
   logic          pop;
   mm_result_type result;

   // Unpack the request beat.
   logic [ACTION_W-1:0] req_action;
   logic [INDEX_W-1:0]  req_row;
   logic [INDEX_W-1:0]  req_col;
   logic [ELEM_W-1:0]   req_value;

   assign req_action = req_tdata[ACTION_W-1:0];
   assign req_row    = req_tdata[COL_LO-1:ROW_LO];
   assign req_col    = req_tdata[VAL_LO-1:COL_LO];
   assign req_value  = req_tdata[VAL_LO+ELEM_W-1:VAL_LO];

   // Front: classify the beat, drop unused actions and out-of-range writes.
   mm_front #(
      .DIM (DIM)
   ) u_front (
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_action),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_value  (req_value),
      .queue_full (queue_full),
      .push       (push)
   );

   // Queue: hold classified work in order so writes and computes never pass each other.
   mm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // Back: apply writes, run the dot-product sweep, hold the result until taken.
   mm_back #(
      .DIM (DIM)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // Pack the result beat; the top bits are zero fill.
   assign rsp_tdata = {{(RSP_DATA_W-RSP_USED_W){1'b0}}, result.sum, result.col, result.row};

endmodule : matrix_multiply

`default_nettype wire
